### design/hnc_pkg.sv
// Shared types and constants of the heightmap normal and curvature block.
package hnc_pkg;

  localparam int MAX_RES_DEF = 1024;

  localparam logic [10:0] RES_RESET  = 11'd256;
  localparam logic [15:0] GAIN_RESET = 16'd256;

  // configuration register indexes
  localparam logic [1:0] CFG_RESOLUTION     = 2'd0;
  localparam logic [1:0] CFG_SLOPE_GAIN     = 2'd1;
  localparam logic [1:0] CFG_CURVATURE_GAIN = 2'd2;

  // item actions
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] height;
  } in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        curvature;
    logic [9:0]         column;
    logic [9:0]         row;
    logic               last_of_frame;
  } out_t;

  // neighbourhood of one pixel handed to the arithmetic unit
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] up;
    logic [15:0] down;
    logic [15:0] center;
  } nbhd_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        curvature;
  } math_res_t;

endpackage

### design/hnc_line_store.sv
// Line store: single-port synchronous RAM holding two heightmap rows.
module hnc_line_store #(
  parameter int DEPTH = 2 * hnc_pkg::MAX_RES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [15:0]   wdata,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/hnc_math.sv
// Arithmetic unit: slopes, curvature, iterative square root and shared serial divider.
module hnc_math (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hnc_pkg::nbhd_t    nb,
  input  logic [15:0]       slope_gain,
  input  logic [15:0]       curvature_gain,
  output logic              done,
  output hnc_pkg::math_res_t res
);

  typedef enum logic [3:0] {
    M_IDLE, M_SLX, M_SLZ, M_SQX, M_SQZ, M_CURV, M_ROOT, M_DIV, M_DONE
  } mstate_t;

  mstate_t        state;
  hnc_pkg::nbhd_t nq;
  logic [23:0]    ax, az;
  logic           nx_neg, nz_neg;
  logic [49:0]    acc;
  logic [49:0]    rv;
  logic [50:0]    rres;
  logic [49:0]    rbit;
  logic [39:0]    rem;
  logic [39:0]    dsh;
  logic [14:0]    q;
  logic [3:0]     cnt;
  logic [1:0]     sel;

  logic signed [16:0] dx, dz;
  logic signed [33:0] px, pz;
  logic [33:0]        mx, mz;
  logic signed [19:0] lap;
  logic signed [37:0] t;
  logic [50:0]        trial;
  logic [24:0]        n;
  logic [14:0]        qn;
  logic               ge;
  logic [39:0]        num0, num1, num2;

  always_comb begin
    dx    = $signed({1'b0, nq.left}) - $signed({1'b0, nq.right});
    dz    = $signed({1'b0, nq.up}) - $signed({1'b0, nq.down});
    px    = 34'(dx * $signed({1'b0, slope_gain}));
    pz    = 34'(dz * $signed({1'b0, slope_gain}));
    mx    = px[33] ? 34'(-px) : px;
    mz    = pz[33] ? 34'(-pz) : pz;
    lap   = $signed(20'(nq.left)) + $signed(20'(nq.right)) + $signed(20'(nq.up))
          + $signed(20'(nq.down)) - $signed({2'b00, nq.center, 2'b00});
    t     = 38'(lap * $signed({1'b0, curvature_gain})) + 38'sd128 + 38'sd8388608;
    trial = rres + 51'(rbit);
    n     = rres[24:0];
    num0  = {2'b00, ax, 14'd0} + 40'(n >> 1);
    num1  = 40'(1 << 30) + 40'(n >> 1);
    num2  = {2'b00, az, 14'd0} + 40'(n >> 1);
    ge    = rem >= dsh;
    qn    = {q[13:0], ge};
  end

  assign done = (state == M_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      unique case (state)
        M_IDLE: begin
          if (start) begin
            nq    <= nb;
            state <= M_SLX;
          end
        end
        M_SLX: begin
          ax     <= mx[31:8];
          nx_neg <= px[33];
          state  <= M_SLZ;
        end
        M_SLZ: begin
          az     <= mz[31:8];
          nz_neg <= pz[33];
          state  <= M_SQX;
        end
        M_SQX: begin
          acc   <= 50'(ax * ax);
          state <= M_SQZ;
        end
        M_SQZ: begin
          acc   <= acc + 50'(az * az) + 50'(64'd1 << 32);
          state <= M_CURV;
        end
        M_CURV: begin
          if (t < 0) begin
            res.curvature <= '0;
          end else if (t[37:8] > 30'd65535) begin
            res.curvature <= 16'hFFFF;
          end else begin
            res.curvature <= t[23:8];
          end
          rv    <= acc;
          rres  <= '0;
          rbit  <= 50'(64'd1 << 48);
          state <= M_ROOT;
        end
        M_ROOT: begin
          if (rbit == '0) begin
            rem   <= num0;
            dsh   <= {1'b0, n, 14'd0};
            q     <= '0;
            cnt   <= 4'd14;
            sel   <= 2'd0;
            state <= M_DIV;
          end else begin
            if (51'(rv) >= trial) begin
              rv   <= 50'(51'(rv) - trial);
              rres <= (rres >> 1) + 51'(rbit);
            end else begin
              rres <= rres >> 1;
            end
            rbit <= rbit >> 2;
          end
        end
        M_DIV: begin
          if (cnt == 4'd0) begin
            unique case (sel)
              2'd0: res.normal_x <= nx_neg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
              2'd1: res.normal_y <= qn;
              default: res.normal_z <= nz_neg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
            endcase
            dsh <= {1'b0, n, 14'd0};
            q   <= '0;
            cnt <= 4'd14;
            sel <= sel + 2'd1;
            rem <= (sel == 2'd0) ? num1 : num2;
            if (sel == 2'd2) begin
              state <= M_DONE;
            end
          end else begin
            if (ge) begin
              rem <= rem - dsh;
            end
            q   <= qn;
            dsh <= dsh >> 1;
            cnt <= cnt - 4'd1;
          end
        end
        M_DONE: begin
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

### design/heightmap_normal_curvature_top.sv
// Top level of the heightmap normal and curvature block.
//
// Heightmap samples come in on the input channel in raster order (action 0),
// beats qualified by in_valid and refused while in_stall is high. Each sample
// below row zero yields the result of the pixel one row above it; once the
// whole frame is in, drain beats (action 1) yield the last row one pixel each.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data. Writing
// the resolution restarts the frame.
// Throughput: one item at a time. A beat that yields a result uses the single
// line-store port for four neighbour reads and, for samples, the write-back,
// then the arithmetic unit, which is dominated by the 25-step square root and
// three 15-step serial divisions. Samples of row zero and ignored beats are
// taken in the idle state, which stays ready for the next beat.
// The result sits in an output register; a stalled beat holds there while the
// next item is already taken in and worked on, and the unit waits only if a
// new result is ready before the old one has gone.
// Reset (rst, synchronous) loads the default registers, clears the position
// counters and empties the output. The line store is not cleared: a frame
// always writes an entry before it reads it.
module heightmap_normal_curvature_top #(
  parameter int MAX_RESOLUTION = hnc_pkg::MAX_RES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  hnc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hnc_pkg::out_t out_data
);

  localparam int XW = $clog2(MAX_RESOLUTION);
  localparam int RW = $clog2(MAX_RESOLUTION + 1);
  localparam int AW = $clog2(2 * MAX_RESOLUTION);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_GO, S_WAIT, S_PUT} state_t;

  state_t      state;
  logic [10:0] resolution;
  logic [15:0] slope_gain;
  logic [15:0] curvature_gain;
  logic [XW-1:0] col;
  logic [RW-1:0] row;

  // the item at work
  logic [XW-1:0] x_q;
  logic [RW-1:0] y_q;
  logic [15:0]   h_q;
  logic          drain_q;
  logic          last_q;
  logic [2:0]    step;
  logic [15:0]   nbr [4];

  logic [RW-1:0] res_eff;
  logic          accept;
  logic          last_col;
  logic          xq_last;
  logic [XW-1:0] xm, xp;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem_rdata;
  logic              math_done;
  hnc_pkg::nbhd_t    nb;
  hnc_pkg::math_res_t mres;

  function automatic logic [AW-1:0] st_addr(input logic half, input logic [XW-1:0] c);
    st_addr = half ? AW'(MAX_RESOLUTION) + AW'(c) : AW'(c);
  endfunction

  // clamp the written resolution to between 2 and what the store holds
  always_comb begin
    if (resolution < 11'd2) begin
      res_eff = RW'(2);
    end else if (32'(resolution) > 32'(MAX_RESOLUTION)) begin
      res_eff = RW'(MAX_RESOLUTION);
    end else begin
      res_eff = RW'(resolution);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign last_col = (RW'(col) + RW'(1)) >= res_eff;
  assign xq_last  = (RW'(x_q) + RW'(1)) >= res_eff;
  assign xm       = (x_q == '0) ? x_q : x_q - XW'(1);
  assign xp       = xq_last ? x_q : x_q + XW'(1);

  // line-store port: row zero writes at once, otherwise four reads then write-back (none for drain beats)
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = st_addr(1'b0, col);
    mem_wdata = in_data.height;
    if (state == S_IDLE) begin
      mem_we = accept && (in_data.action == hnc_pkg::ACT_SAMPLE) && (row == '0);
    end else if (state == S_READ) begin
      mem_wdata = h_q;
      unique case (step)
        3'd0: mem_addr = st_addr(y_q[0], x_q);
        3'd1: mem_addr = st_addr(y_q[0], xm);
        3'd2: mem_addr = st_addr(y_q[0], xp);
        3'd3: mem_addr = (y_q == '0) ? st_addr(y_q[0], x_q) : st_addr(~y_q[0], x_q);
        default: begin
          mem_addr = st_addr(~y_q[0], x_q);
          mem_we   = !drain_q;
        end
      endcase
    end
  end

  hnc_line_store #(.DEPTH(2 * MAX_RESOLUTION)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    nb.center = nbr[0];
    nb.left   = nbr[1];
    nb.right  = nbr[2];
    nb.up     = nbr[3];
    nb.down   = drain_q ? nbr[0] : h_q;
  end

  hnc_math u_math (
    .clk            (clk),
    .rst            (rst),
    .start          (state == S_GO),
    .nb             (nb),
    .slope_gain     (slope_gain),
    .curvature_gain (curvature_gain),
    .done           (math_done),
    .res            (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      resolution     <= hnc_pkg::RES_RESET;
      slope_gain     <= hnc_pkg::GAIN_RESET;
      curvature_gain <= hnc_pkg::GAIN_RESET;
      col            <= '0;
      row            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hnc_pkg::CFG_RESOLUTION: begin
            resolution <= cfg_data[10:0];
            col        <= '0;
            row        <= '0;
          end
          hnc_pkg::CFG_SLOPE_GAIN:     slope_gain     <= cfg_data;
          hnc_pkg::CFG_CURVATURE_GAIN: curvature_gain <= cfg_data;
          default: ;
        endcase
      end

      // drop the output beat once taken, unless a new one replaces it
      if (out_valid && !out_stall && state != S_PUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            step <= 3'd0;
            h_q  <= in_data.height;
            x_q  <= col;
            if (in_data.action == hnc_pkg::ACT_SAMPLE) begin
              if (row < res_eff) begin
                if (last_col) begin
                  col <= '0;
                  row <= row + RW'(1);
                end else begin
                  col <= col + XW'(1);
                end
                if (row != '0) begin
                  y_q     <= row - RW'(1);
                  drain_q <= 1'b0;
                  last_q  <= 1'b0;
                  state   <= S_READ;
                end
              end
            end else if (row >= res_eff) begin
              y_q     <= res_eff - RW'(1);
              drain_q <= 1'b1;
              last_q  <= last_col;
              state   <= S_READ;
              if (last_col) begin
                col <= '0;
                row <= '0;
              end else begin
                col <= col + XW'(1);
              end
            end
          end
        end
        S_READ: begin
          if (step != 3'd0) begin
            nbr[step[1:0] - 2'd1] <= mem_rdata;
          end
          step <= step + 3'd1;
          if (step == 3'd4) begin
            state <= S_GO;
          end
        end
        S_GO: state <= S_WAIT;
        S_WAIT: begin
          if (math_done) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_data.normal_x      <= mres.normal_x;
            out_data.normal_y      <= mres.normal_y;
            out_data.normal_z      <= mres.normal_z;
            out_data.curvature     <= mres.curvature;
            out_data.column        <= 10'(x_q);
            out_data.row           <= 10'(y_q);
            out_data.last_of_frame <= last_q;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/hnc_checker.sv
// Port checker for the heightmap normal and curvature block, bound to the top level.
module hnc_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input hnc_pkg::out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output beat withdrawn");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled output beat changed");

  a_ny_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.normal_y != 15'd0 && out_data.normal_y <= 15'd16384)
    else $error("normal y out of range");

  a_nx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.normal_x >= -16'sd16384 && out_data.normal_x <= 16'sd16384)
    else $error("normal x out of range");

endmodule

bind heightmap_normal_curvature_top hnc_checker u_hnc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/tb_heightmap_normal_curvature_top.sv
// Testbench of the heightmap normal and curvature block: stimulus, prediction and checking.
`timescale 1ns / 1ps

module tb_heightmap_normal_curvature_top;

  localparam int MAX_RES    = 1024;
  localparam int CYCLE_CAP  = 1500000;
  localparam int SETTLE     = 120;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = hnc_pkg::CFG_RESOLUTION;
  logic [15:0]   cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  hnc_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  hnc_pkg::out_t out_data;

  heightmap_normal_curvature_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block: registers, raster position and the two-row line store.
  int unsigned    res_reg = 256, slope_k = 256, curv_k = 256;
  int unsigned    pos_col = 0, pos_row = 0;
  logic [15:0]    rows_mem [2*MAX_RES];
  hnc_pkg::out_t  pixel_q[$];        // results still owed by the block

  int           mismatches = 0;
  int           results_due = 0;   // beats that owe a result, to size the random part
  int           send_idle = 0;     // percent of cycles the sender sits idle
  int           recv_idle = 0;     // percent of cycles the receiver stalls
  int           hold_req = 0;      // long receiver hold-off, picked up by the stall process
  int           cycles = 0;

  function automatic int unsigned act_res();
    if (res_reg < 2) return 2;
    if (res_reg > MAX_RES) return MAX_RES;
    return res_reg;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] unit_comp(longint unsigned mag, bit neg, longint unsigned n);
    longint unsigned m;
    m = (mag * 16384 + n / 2) / n;
    return neg ? 16'(-m) : 16'(m);
  endfunction

  function automatic logic [15:0] stored(int unsigned y, int unsigned x);
    return rows_mem[(y & 1) * MAX_RES + x];
  endfunction

  // Normal and curvature of pixel (x, y); below is the sample one row down.
  function automatic hnc_pkg::out_t shade_pixel(int unsigned x, int unsigned y,
                                                int unsigned res, logic [15:0] below,
                                                bit last);
    hnc_pkg::out_t px;
    int unsigned xm, xp;
    longint c, l, r, u, d, dx, dz, lap, t;
    longint unsigned ax, az, n, cv;
    xm = (x > 0) ? x - 1 : 0;
    xp = (x + 1 < res) ? x + 1 : res - 1;
    c = stored(y, x);
    l = stored(y, xm);
    r = stored(y, xp);
    u = (y > 0) ? longint'(stored(y - 1, x)) : c;
    d = below;
    dx = (l - r) * longint'(slope_k);
    dz = (u - d) * longint'(slope_k);
    ax = (dx < 0 ? -dx : dx) >> 8;
    az = (dz < 0 ? -dz : dz) >> 8;
    n = int_sqrt(ax * ax + az * az + (64'd1 << 32));
    lap = l + r + u + d - 4 * c;
    t = lap * longint'(curv_k) + 128 + 8388608;
    if (t < 0) cv = 0;
    else begin
      cv = t >>> 8;
      if (cv > 65535) cv = 65535;
    end
    px.normal_x = unit_comp(ax, dx < 0, n);
    px.normal_y = 15'(((64'd1 << 30) + n / 2) / n);
    px.normal_z = unit_comp(az, dz < 0, n);
    px.curvature = 16'(cv);
    px.column = 10'(x);
    px.row = 10'(y);
    px.last_of_frame = last;
    return px;
  endfunction

  // Advance the shadow by one accepted beat; returns 1 and the pixel if it yields one.
  function automatic bit advance_raster(hnc_pkg::in_t it, output hnc_pkg::out_t px);
    int unsigned res, x, y;
    bit last;
    res = act_res();
    x = (pos_col >= res) ? res - 1 : pos_col;
    px = '0;
    if (it.action == hnc_pkg::ACT_SAMPLE) begin
      if (pos_row >= res) return 0;      // frame waits to be drained: drop
      if (pos_row > 0) px = shade_pixel(x, pos_row - 1, res, it.height, 1'b0);
      rows_mem[(pos_row & 1) * MAX_RES + x] = it.height;
      if (x + 1 >= res) begin
        pos_col = 0;
        pos_row++;
      end else pos_col = x + 1;
      return pos_row > 0 && !(pos_col == 0 && pos_row == 1) ||
             (pos_col == 0 && pos_row > 1);
    end
    if (pos_row < res) return 0;         // nothing to drain: drop
    y = res - 1;
    last = (x + 1 >= res);
    px = shade_pixel(x, y, res, stored(y, x), last);
    if (last) begin
      pos_col = 0;
      pos_row = 0;
    end else pos_col = x + 1;
    return 1;
  endfunction

  // Offer one beat, after random idle cycles, and hold it until taken.
  task automatic offer(hnc_pkg::in_t it, bit use_typed = 0, hnc_pkg::out_t typed = '0);
    hnc_pkg::out_t px;
    bit yields;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    yields = advance_raster(it, px);
    if (yields) begin
      pixel_q.push_back(use_typed ? typed : px);
      results_due++;
    end
  endtask

  // Lower valid, let every owed result drain out, then settle and write one register.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hnc_pkg::CFG_RESOLUTION: begin
        res_reg = val[10:0];
        pos_col = 0;
        pos_row = 0;
      end
      hnc_pkg::CFG_SLOPE_GAIN:     slope_k = val;
      hnc_pkg::CFG_CURVATURE_GAIN: curv_k = val;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_height(int mode, int unsigned x, int unsigned y);
    case (mode)
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      2: return 16'(16'h8000 + x * 97 + y * 211 + $urandom_range(63));
      default: return 16'h4321;
    endcase
  endfunction

  // Send one full frame at the current resolution, then drain its last row.
  task automatic run_frame(int mode);
    int unsigned res;
    hnc_pkg::in_t it;
    res = act_res();
    for (int unsigned y = 0; y < res; y++)
      for (int unsigned x = 0; x < res; x++) begin
        it.action = hnc_pkg::ACT_SAMPLE;
        it.height = pick_height(mode, x, y);
        offer(it);
      end
    for (int unsigned x = 0; x < res; x++) begin
      it.action = hnc_pkg::ACT_DRAIN;
      it.height = 16'($urandom);
      offer(it);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    int hold_left;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Compare each beat that leaves the block with the oldest owed pixel.
  always @(posedge clk) begin
    hnc_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        want = pixel_q.pop_front();
        if (out_data.normal_x !== want.normal_x || out_data.normal_y !== want.normal_y ||
            out_data.normal_z !== want.normal_z || out_data.curvature !== want.curvature ||
            out_data.column !== want.column || out_data.row !== want.row ||
            out_data.last_of_frame !== want.last_of_frame) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("heightmap_normal_curvature_top test failed");
      $finish;
    end
  end

  typedef struct {
    logic          act;
    logic [15:0]   h;
    bit            typed;
    hnc_pkg::out_t want;
  } stim_row_t;

  function automatic hnc_pkg::out_t flat_px(int unsigned x, int unsigned y, bit last);
    hnc_pkg::out_t px;
    px = '{normal_x: 16'sd0, normal_y: 15'd16384, normal_z: 16'sd0, curvature: 16'd32768,
           column: 10'(x), row: 10'(y), last_of_frame: last};
    return px;
  endfunction

  initial begin
    stim_row_t dir_tab[$];
    hnc_pkg::in_t it;
    int frame_no, res_pick, mode;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 2x2 frames. A flat frame has a straight-up normal and one-half curvature.
    dir_tab = '{
      '{hnc_pkg::ACT_DRAIN,  16'h1234, 1'b0, '0},     // drain with nothing pending
      '{hnc_pkg::ACT_SAMPLE, 16'hFFFF, 1'b0, '0},
      '{hnc_pkg::ACT_SAMPLE, 16'hFFFF, 1'b0, '0},
      '{hnc_pkg::ACT_SAMPLE, 16'hFFFF, 1'b1, flat_px(0, 0, 0)},
      '{hnc_pkg::ACT_SAMPLE, 16'hFFFF, 1'b1, flat_px(1, 0, 0)},
      '{hnc_pkg::ACT_SAMPLE, 16'h0000, 1'b0, '0},     // sample while drain pending
      '{hnc_pkg::ACT_DRAIN,  16'h0000, 1'b1, flat_px(0, 1, 0)},
      '{hnc_pkg::ACT_DRAIN,  16'h0000, 1'b1, flat_px(1, 1, 1)},
      '{hnc_pkg::ACT_SAMPLE, 16'h0000, 1'b0, '0},     // extremes, checked by prediction
      '{hnc_pkg::ACT_SAMPLE, 16'hFFFF, 1'b0, '0},
      '{hnc_pkg::ACT_SAMPLE, 16'hFFFF, 1'b0, '0},
      '{hnc_pkg::ACT_SAMPLE, 16'h0000, 1'b0, '0},
      '{hnc_pkg::ACT_DRAIN,  16'hFFFF, 1'b0, '0},
      '{hnc_pkg::ACT_DRAIN,  16'hFFFF, 1'b0, '0},
      '{hnc_pkg::ACT_DRAIN,  16'hFFFF, 1'b0, '0}      // drain after the frame closed
    };
    write_reg(hnc_pkg::CFG_RESOLUTION, 16'd2);
    foreach (dir_tab[i]) begin
      it.action = dir_tab[i].act;
      it.height = dir_tab[i].h;
      offer(it, dir_tab[i].typed, dir_tab[i].want);
    end
    // Gain extremes: maximum on a steep frame, zero on a random one.
    write_reg(hnc_pkg::CFG_SLOPE_GAIN, 16'hFFFF);
    write_reg(hnc_pkg::CFG_CURVATURE_GAIN, 16'hFFFF);
    run_frame(1);
    write_reg(hnc_pkg::CFG_SLOPE_GAIN, 16'h0000);
    write_reg(hnc_pkg::CFG_CURVATURE_GAIN, 16'h0000);
    run_frame(0);
    // Resolution below the supported range acts as 2.
    write_reg(hnc_pkg::CFG_RESOLUTION, 16'd0);
    run_frame(0);
    write_reg(hnc_pkg::CFG_RESOLUTION, 16'd1);
    run_frame(1);

    // Widest frames: part of row zero, then abandon.
    write_reg(hnc_pkg::CFG_SLOPE_GAIN, 16'd300);
    write_reg(hnc_pkg::CFG_RESOLUTION, 16'd1024);
    for (int i = 0; i < 100; i++) begin
      it.action = hnc_pkg::ACT_SAMPLE;
      it.height = 16'($urandom);
      offer(it);
    end
    write_reg(hnc_pkg::CFG_RESOLUTION, 16'h07FF);   // above the maximum: acts as 1024
    for (int i = 0; i < 40; i++) begin
      it.action = hnc_pkg::ACT_SAMPLE;
      it.height = 16'($urandom);
      offer(it);
    end

    // Random frames, cycling through the idling phases.
    frame_no = 0;
    while (results_due < 380) begin
      case (frame_no % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 47; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 47; end
        default: begin send_idle = 31; recv_idle = 31; end
      endcase
      if ($urandom_range(2) == 0)
        write_reg(hnc_pkg::CFG_SLOPE_GAIN,
                  $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(1023)));
      if ($urandom_range(2) == 0)
        write_reg(hnc_pkg::CFG_CURVATURE_GAIN,
                  $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1023)));
      res_pick = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(2, 5);
      write_reg(hnc_pkg::CFG_RESOLUTION, 16'(res_pick));
      mode = $urandom_range(3);
      if (frame_no == 3) begin
        // Hold the receiver off long enough for the block to back up onto its input.
        send_idle = 0;
        hold_req = 3000;
      end
      if ($urandom_range(9) == 0) begin
        // Broken frame: a partial picture, then one drain beat, then a restart.
        for (int i = 0; i < res_pick * 2 + 1; i++) begin
          it.action = hnc_pkg::ACT_SAMPLE;
          it.height = pick_height(mode, i, 0);
          offer(it);
        end
        it.action = hnc_pkg::ACT_DRAIN;
        offer(it);
      end else begin
        run_frame(mode);
      end
      frame_no++;
    end

    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("heightmap_normal_curvature_top test passed");
    end else begin
      $display("heightmap_normal_curvature_top test failed");
    end
    $finish;
  end

endmodule
